// ===== rtl/ikhm_pkg.sv =====
`timescale 1ns / 1ps

package ikhm_pkg;

  // default geometry
  localparam int unsigned BUCKETS_DEF = 64;
  localparam int unsigned WAYS_DEF    = 4;

  // hash constants
  localparam logic [31:0] HASH_MUL   = 32'h045d_9f3b;
  localparam int unsigned HASH_SHIFT = 16;

  // request commands
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // result of one request
  typedef struct packed {
    logic [31:0] value;
    logic        found;
    logic        full_res;
  } result_t;

  // x ^ (x >> 16)
  function automatic logic [31:0] xor_shift(input logic [31:0] x);
    xor_shift = x ^ (x >> HASH_SHIFT);
  endfunction

endpackage

// ===== rtl/ikhm_if.sv =====
`timescale 1ns / 1ps

// request channel
interface ikhm_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] key;
  logic        [31:0] default_value;

  modport source (output valid, output cmd, output key, output default_value, input ready);
  modport sink   (input valid, input cmd, input key, input default_value, output ready);
endinterface

// response channel
interface ikhm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        found;
  logic        full_res;

  modport source (output valid, output value, output found, output full_res, input ready);
  modport sink   (input valid, input value, input found, input full_res, output ready);
endinterface

// ===== rtl/ikhm_ram.sv =====
`timescale 1ns / 1ps

module ikhm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port, registered read that holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ikhm_hash.sv =====
`timescale 1ns / 1ps

module ikhm_hash (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [31:0] key_i,
  output logic [31:0] hash_o
);

  logic [31:0] h_q;
  logic [31:0] h_d;
  logic [31:0] mul_in;

  // one shared multiplier: first round from the key, second from the register
  assign mul_in = load_i ? ikhm_pkg::xor_shift(key_i) : ikhm_pkg::xor_shift(h_q);
  assign h_d    = mul_in * ikhm_pkg::HASH_MUL;

  always_ff @(posedge clk_i) begin
    if (load_i || step_i) begin
      h_q <= h_d;
    end
  end

  // final xor-shift
  assign hash_o = ikhm_pkg::xor_shift(h_q);

endmodule

// ===== rtl/ikhm_match.sv =====
`timescale 1ns / 1ps

module ikhm_match #(
  parameter int unsigned WAYS   = ikhm_pkg::WAYS_DEF,
  parameter int unsigned FILL_W = $clog2(WAYS + 1),
  parameter int unsigned ROW_W  = FILL_W + WAYS * 64
) (
  input  logic [ROW_W-1:0]  row_i,
  input  logic              cmd_i,
  input  logic [31:0]       key_i,
  input  logic [31:0]       dflt_i,
  output ikhm_pkg::result_t res_o,
  output logic              wr_en_o,
  output logic [ROW_W-1:0]  wr_row_o
);

  localparam int unsigned VAL_BASE  = WAYS * 32;
  localparam int unsigned FILL_BASE = WAYS * 64;

  logic [FILL_W-1:0] fill;
  logic [31:0]       hit_value;
  logic              hit;
  logic              room;
  logic              is_insert;

  assign fill      = row_i[FILL_BASE +: FILL_W];
  assign room      = fill < FILL_W'(WAYS);
  assign is_insert = cmd_i == ikhm_pkg::CMD_INSERT;

  // way compare, the earliest filled slot wins
  always_comb begin
    hit       = 1'b0;
    hit_value = dflt_i;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if ((FILL_W'(w) < fill) && (row_i[w*32 +: 32] == key_i)) begin
        hit       = 1'b1;
        hit_value = row_i[VAL_BASE + w*32 +: 32];
      end
    end
  end

  // append into the next free slot
  always_comb begin
    wr_row_o = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (FILL_W'(w) == fill) begin
        wr_row_o[w*32 +: 32]            = key_i;
        wr_row_o[VAL_BASE + w*32 +: 32] = dflt_i;
      end
    end
    wr_row_o[FILL_BASE +: FILL_W] = fill + FILL_W'(1);
  end

  assign wr_en_o        = is_insert && !hit && room;
  assign res_o.value    = hit_value;
  assign res_o.found    = hit;
  assign res_o.full_res = is_insert && !hit && !room;

endmodule

// ===== rtl/int_key_hash_map.sv =====
`timescale 1ns / 1ps

// Hash map with 32-bit integer keys, up to WAYS entries in each of BUCKETS
// buckets. Requests arrive on req_i (cmd, key, default_value): a lookup
// returns the stored value or the default; an insert adds the key with the
// default value when it is absent and returns the existing value when it is
// present. Each request gives one transfer on rsp_o (value, found, full_res);
// full_res marks an insert into a full bucket, which stores nothing.
// The key hash runs a round on the key, then a round on its register,
// through one shared 32x32 multiplier; the bucket row is then read from the
// table RAM, and then the ways are compared and the row is written back.
// Requests are handled one at a time, so reads and write-backs never
// overlap; a new request is taken only once the last one has left the
// compare step. Reset: after rst_ni is released a clearing pass writes
// every bucket row empty, one row a cycle; req_i.ready stays low until it
// is done. Stall: the result waits in the output register; the next
// request is taken meanwhile, but its result is held in the compare step
// until rsp_o.ready frees the output register.
module int_key_hash_map #(
  parameter int unsigned BUCKETS = ikhm_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = ikhm_pkg::WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ikhm_req_if.sink          req_i,
  ikhm_rsp_if.source        rsp_o
);

  localparam int unsigned BUCKET_W = $clog2(BUCKETS);
  localparam int unsigned FILL_W   = $clog2(WAYS + 1);
  localparam int unsigned ROW_W    = FILL_W + WAYS * 64;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_CMP  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic                clr_q, clr_d;
  logic [BUCKET_W-1:0] clr_idx_q, clr_idx_d;
  logic                out_valid_q, out_valid_d;
  ikhm_pkg::result_t   out_q;
  logic                cmd_q;
  logic [31:0]         key_q;
  logic [31:0]         dflt_q;
  logic [BUCKET_W-1:0] bucket_q;

  logic                req_xfer;
  logic                out_load;
  logic [31:0]         hash;
  logic [BUCKET_W-1:0] bucket;
  logic [ROW_W-1:0]    row_rd;
  logic [ROW_W-1:0]    row_wr;
  logic                upd_we;
  ikhm_pkg::result_t   res;
  logic                ram_we;
  logic [BUCKET_W-1:0] ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;

  assign req_i.ready = (state_q == ST_IDLE) && !clr_q;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign out_load    = (state_q == ST_CMP) && (!out_valid_q || rsp_o.ready);
  assign bucket      = hash[BUCKET_W-1:0];

  // key hash
  ikhm_hash u_hash (
    .clk_i  (clk_i),
    .load_i (req_xfer),
    .step_i (state_q == ST_HASH),
    .key_i  (req_i.key),
    .hash_o (hash)
  );

  // bucket table: fill count, keys and values of one bucket per row
  ikhm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == ST_READ),
    .raddr_i (bucket),
    .rdata_o (row_rd)
  );

  // way compare and append
  ikhm_match #(
    .WAYS   (WAYS),
    .FILL_W (FILL_W),
    .ROW_W  (ROW_W)
  ) u_match (
    .row_i    (row_rd),
    .cmd_i    (cmd_q),
    .key_i    (key_q),
    .dflt_i   (dflt_q),
    .res_o    (res),
    .wr_en_o  (upd_we),
    .wr_row_o (row_wr)
  );

  // write port: clearing pass or write-back
  assign ram_we    = clr_q || (out_load && upd_we);
  assign ram_waddr = clr_q ? clr_idx_q : bucket_q;
  assign ram_wdata = clr_q ? '0 : row_wr;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // clearing pass after reset
  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + BUCKET_W'(1);
      if (clr_idx_q == BUCKET_W'(BUCKETS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_q       <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      cmd_q  <= req_i.cmd;
      key_q  <= req_i.key;
      dflt_q <= req_i.default_value;
    end
    if (state_q == ST_READ) begin
      bucket_q <= bucket;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.value    = out_q.value;
  assign rsp_o.found    = out_q.found;
  assign rsp_o.full_res = out_q.full_res;

  // checks
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_found_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(res.found && res.full_res))
    else $error("result both found and full");

  a_we_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (clr_q || state_q == ST_CMP))
    else $error("table write outside compare step");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule
